### sv/double_hash_table_lookup_insert_macros.svh
// Assertion macros for the double-hash table block.
`ifndef DOUBLE_HASH_TABLE_LOOKUP_INSERT_MACROS_SVH
`define DOUBLE_HASH_TABLE_LOOKUP_INSERT_MACROS_SVH

`ifndef SYNTH
// Check a consequent in the same cycle as its antecedent.
`define DHT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dht assertion failed");
// Check a consequent in the cycle after its antecedent.
`define DHT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dht assertion failed");
`else
`define DHT_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define DHT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### sv/dht_pkg.sv
`timescale 1ns / 1ps

package dht_pkg;

	// Default geometry
	localparam int DHT_TABLE_SIZE = 4093;
	localparam int DHT_KEY_BITS   = 16;
	localparam int DHT_DIST_BITS  = 8;

	// Secondary hash: stride = STRIDE_BASE - key mod STRIDE_BASE
	localparam int STRIDE_BASE = 911;
	localparam int STRIDE_W    = 10;

	typedef enum logic [1:0] {
		ST_HIT    = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic cap;
		logic clr;
		logic hash_ld;
		logic rd;
		logic adv;
		logic wr;
		logic res_hit;
		logic res_absent;
		logic res_full;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic is_ins;
		logic slot_vld;
		logic key_hit;
		logic last_probe;
	} sts_t;

endpackage

### sv/dht_ctrl.sv
`timescale 1ns / 1ps

module dht_ctrl import dht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_H1    = 7'b0000100,
		S_H2    = 7'b0001000,
		S_H3    = 7'b0010000,
		S_RD    = 7'b0100000,
		S_CHK   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Decode next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_H1;
				end
			end
			S_H1: begin
				state_d = S_H2;
			end
			S_H2: begin
				state_d = S_H3;
			end
			S_H3: begin
				cmd.hash_ld = 1'b1;
				state_d     = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				// Insert takes the first free slot; lookup stops on empty or match
				priority if (!sts.slot_vld) begin
					if (sts.is_ins) begin
						cmd.wr      = 1'b1;
						cmd.res_hit = 1'b1;
					end else begin
						cmd.res_absent = 1'b1;
					end
					state_d = S_IDLE;
				end else if (!sts.is_ins && sts.key_hit) begin
					cmd.res_hit = 1'b1;
					state_d     = S_IDLE;
				end else if (sts.last_probe) begin
					cmd.res_full = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### sv/dht_dp.sv
`timescale 1ns / 1ps

module dht_dp import dht_pkg::*; #(
	parameter int TABLE_SIZE = DHT_TABLE_SIZE,
	parameter int KEY_BITS   = DHT_KEY_BITS,
	parameter int DIST_BITS  = DHT_DIST_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic                         kind,
	input  logic [KEY_BITS-1:0]          search_key,
	input  logic [KEY_BITS-1:0]          parent_key,
	input  logic [DIST_BITS-1:0]         parent_distance,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [$clog2(TABLE_SIZE)-1:0] slot_index,
	output logic [DIST_BITS-1:0]         found_distance,
	output logic [KEY_BITS-1:0]          found_parent
);

	localparam int IdxW  = $clog2(TABLE_SIZE);
	localparam int WordW = 1 + 2 * KEY_BITS + DIST_BITS;
	localparam longint unsigned RecipT = (64'd1 << KEY_BITS) / TABLE_SIZE;
	localparam longint unsigned RecipS = (64'd1 << KEY_BITS) / STRIDE_BASE;
	localparam logic [KEY_BITS-1:0] RecipTK = KEY_BITS'(RecipT);
	localparam logic [KEY_BITS-1:0] RecipSK = KEY_BITS'(RecipS);
	localparam logic [31:0] SizeC = 32'(TABLE_SIZE);
	localparam logic [31:0] BaseC = 32'(STRIDE_BASE);

	// Captured request
	logic                 kind_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [KEY_BITS-1:0]  par_q;
	logic [DIST_BITS-1:0] pdist_q;

	// Hash pipeline
	logic [2*KEY_BITS-1:0] mt;
	logic [2*KEY_BITS-1:0] ms;
	logic [KEY_BITS-1:0]   qt_s1;
	logic [KEY_BITS-1:0]   qs_s1;
	logic [31:0]           mpt;
	logic [31:0]           mps;
	logic [KEY_BITS-1:0]   pt_s2;
	logic [KEY_BITS-1:0]   ps_s2;
	logic [31:0]           rt;
	logic [31:0]           rs;
	logic [31:0]           rtc;
	logic [31:0]           rsc;

	// Probe state
	logic [IdxW-1:0]     pos_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [IdxW-1:0]     cnt_q;
	logic [IdxW:0]       sum;
	logic [IdxW-1:0]     pos_nx;

	// Slot memory
	logic [WordW-1:0] mem [TABLE_SIZE];
	logic [WordW-1:0] rd_q;
	logic [WordW-1:0] wr_word;
	logic [IdxW-1:0]  clr_q;
	logic                 rd_vld;
	logic [KEY_BITS-1:0]  rd_key;
	logic [KEY_BITS-1:0]  rd_par;
	logic [DIST_BITS-1:0] rd_dist;
	logic [DIST_BITS-1:0] new_dist;

	// Result registers
	logic                 done_q;
	status_t              status_q;
	logic [IdxW-1:0]      slot_q;
	logic [DIST_BITS-1:0] fdist_q;
	logic [KEY_BITS-1:0]  fpar_q;

	// Capture the request word
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q  <= kind;
			key_q   <= search_key;
			par_q   <= parent_key;
			pdist_q <= parent_distance;
		end
	end

	// Estimate quotients by reciprocal multiply
	assign mt = key_q * RecipTK;
	assign ms = key_q * RecipSK;
	assign mpt = 32'(qt_s1) * SizeC;
	assign mps = 32'(qs_s1) * BaseC;

	always_ff @(posedge clk) begin
		qt_s1 <= mt[2*KEY_BITS-1:KEY_BITS];
		qs_s1 <= ms[2*KEY_BITS-1:KEY_BITS];
		pt_s2 <= KEY_BITS'(mpt);
		ps_s2 <= KEY_BITS'(mps);
	end

	// Remainders, one correction each
	assign rt  = 32'(key_q) - 32'(pt_s2);
	assign rs  = 32'(key_q) - 32'(ps_s2);
	assign rtc = (rt >= SizeC) ? rt - SizeC : rt;
	assign rsc = (rs >= BaseC) ? rs - BaseC : rs;

	// Step to the next slot on the probe path
	assign sum    = {1'b0, pos_q} + (IdxW + 1)'(stride_q);
	assign pos_nx = (sum >= (IdxW + 1)'(TABLE_SIZE)) ?
		IdxW'(sum - (IdxW + 1)'(TABLE_SIZE)) : IdxW'(sum);

	always_ff @(posedge clk) begin
		if (cmd.hash_ld) begin
			pos_q    <= IdxW'(rtc);
			stride_q <= STRIDE_W'(BaseC - rsc);
			cnt_q    <= '0;
		end else if (cmd.adv) begin
			pos_q <= pos_nx;
			cnt_q <= cnt_q + IdxW'(1);
		end
	end

	// Sweep the memory clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + IdxW'(1);
		end
	end

	assign new_dist = (&pdist_q) ? pdist_q : pdist_q + DIST_BITS'(1);
	assign wr_word  = {1'b1, key_q, par_q, new_dist};

	// Single write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr) begin
			mem[pos_q] <= wr_word;
		end
		if (cmd.rd) begin
			rd_q <= mem[pos_q];
		end
	end

	assign rd_vld  = rd_q[WordW-1];
	assign rd_key  = rd_q[WordW-2 -: KEY_BITS];
	assign rd_par  = rd_q[DIST_BITS +: KEY_BITS];
	assign rd_dist = rd_q[DIST_BITS-1:0];

	assign sts.clr_last   = (clr_q == IdxW'(TABLE_SIZE - 1));
	assign sts.is_ins     = kind_q;
	assign sts.slot_vld   = rd_vld;
	assign sts.key_hit    = (rd_key == key_q);
	assign sts.last_probe = (cnt_q == IdxW'(TABLE_SIZE - 1));

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.res_hit) begin
			status_q <= ST_HIT;
			slot_q   <= pos_q;
			fdist_q  <= kind_q ? new_dist : rd_dist;
			fpar_q   <= kind_q ? par_q : rd_par;
		end else if (cmd.res_absent || cmd.res_full) begin
			status_q <= cmd.res_full ? ST_FULL : ST_ABSENT;
			slot_q   <= '0;
			fdist_q  <= '0;
			fpar_q   <= '0;
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_hit | cmd.res_absent | cmd.res_full;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign slot_index     = slot_q;
	assign found_distance = fdist_q;
	assign found_parent   = fpar_q;

endmodule

### sv/double_hash_table_lookup_insert.sv
// Each accepted word passes modulo hash states S_H1, S_H2, S_H3; each probe is then one
// read of the slot memory (S_RD) and a check (S_CHK); the result strobe is registered
// from the final check. Busy holds off a new word until the last result is decided.
// Reset: asynchronous, active low; then a clearing pass over all TABLE_SIZE slots
// (4093 by default) with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
`include "double_hash_table_lookup_insert_macros.svh"

module double_hash_table_lookup_insert import dht_pkg::*; #(
	parameter int TABLE_SIZE = DHT_TABLE_SIZE,
	parameter int KEY_BITS   = DHT_KEY_BITS,
	parameter int DIST_BITS  = DHT_DIST_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [KEY_BITS-1:0]           search_key,
	input  logic [KEY_BITS-1:0]           parent_key,
	input  logic [DIST_BITS-1:0]          parent_distance,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [$clog2(TABLE_SIZE)-1:0] slot_index,
	output logic [DIST_BITS-1:0]          found_distance,
	output logic [KEY_BITS-1:0]           found_parent
);

	cmd_t cmd;
	sts_t sts;
	logic payload_zero;

	dht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	dht_dp #(
		.TABLE_SIZE (TABLE_SIZE),
		.KEY_BITS   (KEY_BITS),
		.DIST_BITS  (DIST_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.search_key      (search_key),
		.parent_key      (parent_key),
		.parent_distance (parent_distance),
		.done            (done),
		.status          (status),
		.slot_index      (slot_index),
		.found_distance  (found_distance),
		.found_parent    (found_parent)
	);

	assign payload_zero = (slot_index == '0) && (found_distance == '0) && (found_parent == '0);

	// Results never come on consecutive cycles; an accepted word holds off the result
	`DHT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`DHT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	// Misses and full tables carry zero payload
	`DHT_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && status != ST_HIT, payload_zero)
	// Reported slot lies inside the table
	`DHT_ASSERT_IMPL(a_slot_range, clk, arst_n, done, 32'(slot_index) < 32'(TABLE_SIZE))

endmodule
